// ----- src/rebq_pkg.sv -----
// Shared types and constants for the rotary encoder and push button qualifier.
// Used by the front, the queue, the back and the top level; no dependencies.
package rebq_pkg;

  // Command codes carried on the slave tuser.
  localparam logic [1:0] CMD_BUTTON  = 2'd0;
  localparam logic [1:0] CMD_CHANNEL = 2'd1;
  localparam logic [1:0] CMD_POLL    = 2'd2;
  localparam logic [1:0] CMD_WRITE   = 2'd3;

  // Button classification codes.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_INDEX_BITS   = 3;
  localparam int         CFG_DATA_BITS    = 16;
  localparam logic [2:0] REG_MIN_POSITION = 3'd0;
  localparam logic [2:0] REG_MAX_POSITION = 3'd1;
  localparam logic [2:0] REG_STEP_SLOW    = 3'd2;
  localparam logic [2:0] REG_STEP_FAST    = 3'd3;
  localparam logic [2:0] REG_WRAP_ENABLE  = 3'd4;
  localparam logic [2:0] REG_OVER_PRESS   = 3'd5;

  // Configuration reset values.
  localparam logic signed [15:0] MIN_POSITION_RST = -16'sd32767;
  localparam logic signed [15:0] MAX_POSITION_RST = 16'sd32766;
  localparam logic [7:0]         STEP_SLOW_RST    = 8'd1;
  localparam logic [7:0]         STEP_FAST_RST    = 8'd1;
  localparam logic [15:0]        OVER_PRESS_RST   = 16'd2500;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [15:0] min_position;
    logic signed [15:0] max_position;
    logic [7:0]         step_slow;
    logic [7:0]         step_fast;
    logic               wrap_enable;
    logic [15:0]        over_press_ms;
  } cfg_t;

  // Decoded command: exactly one bit set per item.
  typedef struct packed {
    logic is_write;
    logic is_poll;
    logic is_channel;
    logic is_button;
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        now_ms;
    logic               line_level;
    logic               other_channel_level;
    logic signed [15:0] new_position;
  } item_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } qstat_t;

endpackage

// ----- src/rotary_encoder_button_qualifier_core.sv -----
// Top level of the rotary encoder and push button qualifier: ports, config
// registers and the front / queue / back chain. Depends on rebq_pkg and all
// rebq_* modules.
//
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         tuser: command; tdata: now_ms, line_level,
//                      other_channel_level, new_position
// m_axis    out        tdata: position, button_event, write_ok
// cfg       in         cfg_we / cfg_index / cfg_wdata, one register per write
//
// Every input beat gives exactly one output beat. The block sustains one beat
// per cycle while m_axis_tready is high; a beat passes the front register, the
// queue and the back result register; the back updates all state on a pop.
// rst is synchronous and clears state and the config registers to their
// documented values. Stalls on m_axis fill the output register, then the
// two-entry queue, then the front register before s_axis_tready drops.
module rotary_encoder_button_qualifier_core #(
  parameter int SHORT_PRESS_MS = 1000,
  parameter int FAST_WINDOW_MS = 300,
  parameter int TIME_BITS      = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] now_ms, [32] line_level, [33] other_channel_level,
  // [49:34] new_position, [55:50] zero
  input  logic [55:0]                           s_axis_tdata,
  // [1:0] command
  input  logic [1:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [15:0] position, [17:16] button_event, [18] write_ok, [23:19] zero
  output logic [23:0]                           m_axis_tdata,
  input  logic                                  cfg_we,
  input  logic [rebq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rebq_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import rebq_pkg::*;

  cfg_t               cfg;
  logic               push;
  item_t              push_item;
  item_t              head_item;
  qstat_t             qstat;
  logic               pop;
  logic signed [15:0] out_position;
  logic [1:0]         out_button_event;
  logic               out_write_ok;

  // Configuration registers. Writes to unused indexes fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_position  <= MIN_POSITION_RST;
      cfg.max_position  <= MAX_POSITION_RST;
      cfg.step_slow     <= STEP_SLOW_RST;
      cfg.step_fast     <= STEP_FAST_RST;
      cfg.wrap_enable   <= 1'b0;
      cfg.over_press_ms <= OVER_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_POSITION: cfg.min_position  <= $signed(cfg_wdata[15:0]);
        REG_MAX_POSITION: cfg.max_position  <= $signed(cfg_wdata[15:0]);
        REG_STEP_SLOW:    cfg.step_slow     <= cfg_wdata[7:0];
        REG_STEP_FAST:    cfg.step_fast     <= cfg_wdata[7:0];
        REG_WRAP_ENABLE:  cfg.wrap_enable   <= cfg_wdata[0];
        REG_OVER_PRESS:   cfg.over_press_ms <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // The front decodes and masks; it only stalls when the queue is full.
  rebq_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_command      (s_axis_tuser),
    .in_now_ms       (s_axis_tdata[31:0]),
    .in_line_level   (s_axis_tdata[32]),
    .in_other_level  (s_axis_tdata[33]),
    .in_new_position ($signed(s_axis_tdata[49:34])),
    .push            (push),
    .push_item       (push_item),
    .qstat           (qstat)
  );

  rebq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // The back pops one item whenever its result register is free or drains.
  rebq_back #(
    .SHORT_PRESS_MS (SHORT_PRESS_MS),
    .FAST_WINDOW_MS (FAST_WINDOW_MS),
    .TIME_BITS      (TIME_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .item_valid       (!qstat.empty),
    .item             (head_item),
    .pop              (pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_position     (out_position),
    .out_button_event (out_button_event),
    .out_write_ok     (out_write_ok)
  );

  assign m_axis_tdata = {5'd0, out_write_ok, out_button_event, out_position};

  // The queue never holds more than its depth and never pops when empty.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (qstat.count <= QCNT_BITS'(QUEUE_DEPTH)) && !(pop && qstat.empty))
    else $error("queue count out of range or pop from empty queue");

  // A write acknowledge never comes with a button classification.
  a_ok_excl: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_write_ok) |-> (out_button_event == EV_NONE))
    else $error("write_ok beat carries a button event");

  // A beat accepted on the output with nothing queued leaves the output empty.
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && qstat.empty) |=> !m_axis_tvalid)
    else $error("output beat appeared without a queued item");

endmodule

// ----- src/rebq_front.sv -----
// Front end: accepts input beats, decodes the command and masks the timestamp.
// Depends on rebq_pkg; feeds rebq_queue.
module rebq_front #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_now_ms,
  input  logic                in_line_level,
  input  logic                in_other_level,
  input  logic signed [15:0]  in_new_position,
  output logic                push,
  output rebq_pkg::item_t     push_item,
  input  rebq_pkg::qstat_t    qstat
);
  import rebq_pkg::*;

  localparam logic [31:0] TIME_MASK = 32'hFFFF_FFFF >> (32 - TIME_BITS);

  logic  hold_valid;
  item_t hold;
  kind_t kind_dec;
  logic  take;

  always_comb begin
    kind_dec = '0;
    case (in_command)
      CMD_BUTTON:  kind_dec.is_button  = 1'b1;
      CMD_CHANNEL: kind_dec.is_channel = 1'b1;
      CMD_POLL:    kind_dec.is_poll    = 1'b1;
      CMD_WRITE:   kind_dec.is_write   = 1'b1;
      default:     kind_dec.is_write   = 1'b1;
    endcase
  end

  assign push      = hold_valid && !qstat.full;
  assign push_item = hold;
  assign in_ready  = !hold_valid || !qstat.full;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold.kind                <= kind_dec;
      hold.now_ms              <= in_now_ms & TIME_MASK;
      hold.line_level          <= in_line_level;
      hold.other_channel_level <= in_other_level;
      hold.new_position        <= in_new_position;
    end
  end

endmodule

// ----- src/rebq_queue.sv -----
// Short register queue that decouples the front end from the back end.
// Depends on rebq_pkg for the item type and depth constants.
module rebq_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rebq_pkg::item_t   push_item,
  input  logic              pop,
  output rebq_pkg::item_t   head_item,
  output rebq_pkg::qstat_t  qstat
);
  import rebq_pkg::*;

  localparam logic [QPTR_BITS-1:0] LAST_PTR = QPTR_BITS'(QUEUE_DEPTH - 1);

  item_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign head_item   = entries[rd_ptr];
  assign qstat.count = count;
  assign qstat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- src/rebq_back.sv -----
// Back end: holds the button and encoder state, executes one item per cycle while its result
// register is free or drains, and registers the result beat. Depends on rebq_pkg; fed by rebq_queue.
module rebq_back #(
  parameter int SHORT_PRESS_MS = 1000,
  parameter int FAST_WINDOW_MS = 300,
  parameter int TIME_BITS      = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rebq_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  rebq_pkg::item_t     item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_position,
  output logic [1:0]          out_button_event,
  output logic                out_write_ok
);
  import rebq_pkg::*;

  localparam logic [TIME_BITS-1:0] SHORT_LIMIT = TIME_BITS'(SHORT_PRESS_MS);
  localparam logic [TIME_BITS-1:0] FAST_LIMIT  = TIME_BITS'(FAST_WINDOW_MS);

  // Architectural state.
  logic [TIME_BITS-1:0] press_start;
  logic                 press_valid;
  logic [1:0]           pending_mode;
  logic [TIME_BITS-1:0] turn_start;
  logic                 turn_valid;
  logic                 direction_b_high;
  logic [TIME_BITS-1:0] last_change;
  logic signed [15:0]   position_reg;

  logic [TIME_BITS-1:0] press_start_next;
  logic                 press_valid_next;
  logic [1:0]           pending_mode_next;
  logic [TIME_BITS-1:0] turn_start_next;
  logic                 turn_valid_next;
  logic                 direction_b_high_next;
  logic [TIME_BITS-1:0] last_change_next;
  logic signed [15:0]   position_next;
  logic [1:0]           event_next;
  logic                 ok_next;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] over_limit;
  logic [TIME_BITS-1:0] el_press;
  logic [TIME_BITS-1:0] el_turn;
  logic [TIME_BITS-1:0] el_change;
  logic [7:0]           step_big;
  logic [7:0]           step;
  logic signed [17:0]   pos_wide;
  logic signed [17:0]   step_wide;
  logic signed [17:0]   sum;
  logic signed [17:0]   min_wide;
  logic signed [17:0]   max_wide;
  logic signed [17:0]   p_hi;
  logic signed [17:0]   p_lim;

  assign pop        = item_valid && (!out_valid || out_ready);
  assign now        = item.now_ms[TIME_BITS-1:0];
  assign over_limit = TIME_BITS'(cfg.over_press_ms);
  assign el_press   = now - press_start;
  assign el_turn    = now - turn_start;
  assign el_change  = now - last_change;

  // Step size and limit handling for an encoder detent.
  always_comb begin
    step_big  = (cfg.step_fast > cfg.step_slow) ? cfg.step_fast : cfg.step_slow;
    step      = (el_change < FAST_LIMIT) ? step_big : cfg.step_slow;
    pos_wide  = $signed({{2{position_reg[15]}}, position_reg});
    step_wide = $signed({10'd0, step});
    min_wide  = $signed({{2{cfg.min_position[15]}}, cfg.min_position});
    max_wide  = $signed({{2{cfg.max_position[15]}}, cfg.max_position});
    sum       = direction_b_high ? (pos_wide - step_wide) : (pos_wide + step_wide);
    if (sum > max_wide) begin
      p_hi = cfg.wrap_enable ? min_wide : max_wide;
    end else begin
      p_hi = sum;
    end
    if (p_hi < min_wide) begin
      p_lim = cfg.wrap_enable ? max_wide : min_wide;
    end else begin
      p_lim = p_hi;
    end
  end

  always_comb begin
    press_start_next      = press_start;
    press_valid_next      = press_valid;
    pending_mode_next     = pending_mode;
    turn_start_next       = turn_start;
    turn_valid_next       = turn_valid;
    direction_b_high_next = direction_b_high;
    last_change_next      = last_change;
    position_next         = position_reg;
    event_next            = EV_NONE;
    ok_next               = 1'b0;

    if (item.kind.is_button) begin
      if (!item.line_level) begin
        if (!press_valid || (el_press > over_limit)) begin
          press_start_next = now;
          press_valid_next = 1'b1;
        end
      end else if (press_valid) begin
        if (el_press < SHORT_LIMIT) begin
          pending_mode_next = EV_SHORT;
        end else if (el_press < over_limit) begin
          pending_mode_next = EV_LONG;
        end else begin
          pending_mode_next = EV_NONE;
        end
        press_valid_next = 1'b0;
      end
    end else if (item.kind.is_channel) begin
      if (!item.line_level) begin
        if (!turn_valid || (el_turn > over_limit)) begin
          turn_start_next       = now;
          turn_valid_next       = 1'b1;
          direction_b_high_next = item.other_channel_level;
        end
      end else if (turn_valid) begin
        if (el_turn < over_limit) begin
          last_change_next = now;
          position_next    = p_lim[15:0];
        end
        turn_valid_next = 1'b0;
      end
    end else if (item.kind.is_poll) begin
      if (press_valid && (el_press > SHORT_LIMIT)) begin
        event_next       = EV_LONG;
        press_valid_next = 1'b0;
      end else begin
        event_next = pending_mode;
      end
      pending_mode_next = EV_NONE;
    end else begin
      if ((item.new_position >= cfg.min_position) &&
          (item.new_position <= cfg.max_position)) begin
        position_next = item.new_position;
        ok_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start      <= '0;
      press_valid      <= 1'b0;
      pending_mode     <= EV_NONE;
      turn_start       <= '0;
      turn_valid       <= 1'b0;
      direction_b_high <= 1'b0;
      last_change      <= '0;
      position_reg     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        press_start      <= press_start_next;
        press_valid      <= press_valid_next;
        pending_mode     <= pending_mode_next;
        turn_start       <= turn_start_next;
        turn_valid       <= turn_valid_next;
        direction_b_high <= direction_b_high_next;
        last_change      <= last_change_next;
        position_reg     <= position_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_position     <= position_next;
      out_button_event <= event_next;
      out_write_ok     <= ok_next;
    end
  end

endmodule
